// ===== rtl/double_hash_table_defines.svh =====
// Assertion macros for the hash table RTL.
// DHT_ASSERT is masked while reset is low; DHT_ASSERT_ALWAYS is checked on every edge.
`ifndef DOUBLE_HASH_TABLE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define DHT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hash table assertion failed");
`define DHT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hash table assertion failed");
`else
`define DHT_ASSERT(lbl, clk, rst_n, prop)
`define DHT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/dht_pkg.sv =====
package dht_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

endpackage

// ===== rtl/double_hash_table.sv =====
// Open-addressing hash table with double hashing, one result item per input item.
// Each slot (key plus valid bit) lives in one synchronous RAM of TABLE_DEPTH words.
// After reset the block clears the RAM, one slot per cycle, with in_ready_o low. An item
// then passes through these steps: accept; the residue unit, which folds the key until it
// fits below the table and step moduli, then finishes and hands over (a second folding
// pass is added when STEP_PRIME >= TABLE_DEPTH); issue of the first RAM read; the probes,
// one per cycle; and the load of the output register. The output load waits while the
// previous result is still held in the output register. An insert into a full table
// skips hashing and goes straight to the wait state with a FULL status and slot zero.
// The probe loop reads one slot per cycle on the RAM read port and stops at a match,
// an empty slot, or after TABLE_DEPTH probes. Duplicate keys are not detected.
// One item is in flight at a time; a new item is taken while the previous result still
// sits in the output register.
`include "double_hash_table_defines.svh"

module double_hash_table #(
  parameter int TABLE_DEPTH = 1021,
  parameter int STEP_PRIME  = 1019,
  parameter int KEY_BITS    = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [KEY_BITS-1:0]            key_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] slot_index_o
);

  localparam int SW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = KEY_BITS + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_WAIT} state_e;

  state_e              state_q;
  logic [SW-1:0]       clr_q;
  dht_pkg::opcode_e    op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SW-1:0]       step_q;
  logic [SW-1:0]       iss_q;      // slot whose read is issued this cycle
  logic [SW-1:0]       chk_idx_q;  // slot whose data is on the RAM output
  logic                chk_vld_q;
  logic [SW-1:0]       chk_cnt_q;  // probes checked so far
  logic [OW-1:0]       occ_q;
  dht_pkg::status_e    res_status_q;
  logic [SW-1:0]       res_slot_q;
  logic                out_vld_q;
  dht_pkg::status_e    out_status_q;
  logic [SW-1:0]       out_slot_q;

  logic                in_acc, is_full, hash_start, hash_done;
  logic [SW-1:0]       hash_home, hash_step;
  logic [SW:0]         sum;
  logic [SW-1:0]       iss_adv;
  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata, ram_rdata;
  logic                rd_v;
  logic [KEY_BITS-1:0] rd_key;
  logic                last, ins_hit, dec;
  dht_pkg::status_e    dec_status;
  logic [SW-1:0]       dec_slot;
  logic                out_free, out_load, out_no_slot;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign is_full    = (occ_q >= OW'(TABLE_DEPTH));
  assign hash_start = in_acc &&
                      !((dht_pkg::opcode_e'(opcode_i) == dht_pkg::OP_INSERT) && is_full);

  dht_hash #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .STEP_PRIME (STEP_PRIME),
    .KEY_BITS   (KEY_BITS)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (key_i),
    .done_o (hash_done),
    .home_o (hash_home),
    .step_o (hash_step)
  );

  // next probe slot: step is already reduced below TABLE_DEPTH
  assign sum     = {1'b0, iss_q} + {1'b0, step_q};
  assign iss_adv = (sum >= (SW+1)'(TABLE_DEPTH)) ? SW'(sum - (SW+1)'(TABLE_DEPTH))
                                                 : sum[SW-1:0];

  assign rd_v   = ram_rdata[KEY_BITS];
  assign rd_key = ram_rdata[KEY_BITS-1:0];
  assign last   = (chk_cnt_q == SW'(TABLE_DEPTH - 1));

  assign ins_hit = (state_q == S_PROBE) && chk_vld_q &&
                   (op_q == dht_pkg::OP_INSERT) && !rd_v;

  // probe outcome for the slot on the RAM output
  always_comb begin
    dec        = 1'b0;
    dec_status = dht_pkg::ST_MISSING;
    dec_slot   = '0;
    if (chk_vld_q) begin
      if (op_q == dht_pkg::OP_INSERT) begin
        if (!rd_v) begin
          dec        = 1'b1;
          dec_status = dht_pkg::ST_INSERTED;
          dec_slot   = chk_idx_q;
        end else if (last) begin
          dec        = 1'b1;
          dec_status = dht_pkg::ST_FULL;
        end
      end else begin
        if (!rd_v) begin
          dec        = 1'b1;
          dec_status = dht_pkg::ST_MISSING;
        end else if (rd_key == key_q) begin
          dec        = 1'b1;
          dec_status = dht_pkg::ST_FOUND;
          dec_slot   = chk_idx_q;
        end else if (last) begin
          dec        = 1'b1;
          dec_status = dht_pkg::ST_MISSING;
        end
      end
    end
  end

  // write port: clearing sweep after reset, else the insert commit
  assign ram_we    = (state_q == S_CLEAR) || ins_hit;
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : chk_idx_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, key_q};

  dht_ram #(
    .WIDTH(MW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(iss_q),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_vld_q || out_ready_i;
  // result leaves the wait state into the output register
  assign out_load = (state_q == S_WAIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      op_q         <= dht_pkg::OP_INSERT;
      key_q        <= '0;
      step_q       <= '0;
      iss_q        <= '0;
      chk_idx_q    <= '0;
      chk_vld_q    <= 1'b0;
      chk_cnt_q    <= '0;
      occ_q        <= '0;
      res_status_q <= dht_pkg::ST_INSERTED;
      res_slot_q   <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= dht_pkg::ST_INSERTED;
      out_slot_q   <= '0;
    end else begin
      if (out_load) begin
        out_vld_q    <= 1'b1;
        out_status_q <= res_status_q;
        out_slot_q   <= res_slot_q;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == SW'(TABLE_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_q  <= dht_pkg::opcode_e'(opcode_i);
            key_q <= key_i;
            if (hash_start) begin
              state_q <= S_HASH;
            end else begin
              // insert into a full table: dropped
              res_status_q <= dht_pkg::ST_FULL;
              res_slot_q   <= '0;
              state_q      <= S_WAIT;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            iss_q     <= hash_home;
            step_q    <= hash_step;
            chk_vld_q <= 1'b0;
            chk_cnt_q <= '0;
            state_q   <= S_PROBE;
          end
        end
        S_PROBE: begin
          // reads run one slot ahead; no writes happen before the decision
          iss_q     <= iss_adv;
          chk_idx_q <= iss_q;
          if (dec) begin
            chk_vld_q    <= 1'b0;
            res_status_q <= dec_status;
            res_slot_q   <= dec_slot;
            state_q      <= S_WAIT;
            if (ins_hit) begin
              occ_q <= occ_q + OW'(1);
            end
          end else begin
            chk_vld_q <= 1'b1;
            if (chk_vld_q) begin
              chk_cnt_q <= chk_cnt_q + SW'(1);
            end
          end
        end
        S_WAIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = out_status_q;
  assign slot_index_o = out_slot_q;

  assign out_no_slot = out_vld_q && (out_status_q == dht_pkg::ST_FULL ||
                                     out_status_q == dht_pkg::ST_MISSING);

  `DHT_ASSERT_ALWAYS(a_occ_reset, clk_i, !rst_ni |=> (occ_q == '0))
  `DHT_ASSERT(a_occ_bound, clk_i, rst_ni, occ_q <= OW'(TABLE_DEPTH))
  `DHT_ASSERT(a_probe_idx, clk_i, rst_ni, (state_q == S_PROBE) |-> (iss_q < SW'(TABLE_DEPTH)))
  `DHT_ASSERT(a_occ_incr, clk_i, rst_ni, ins_hit |=> (occ_q == $past(occ_q) + OW'(1)))
  `DHT_ASSERT(a_slot_zero, clk_i, rst_ni, out_no_slot |-> (out_slot_q == '0))
  `DHT_ASSERT(a_no_write_idle, clk_i, rst_ni, (state_q == S_IDLE || state_q == S_WAIT) |-> !ram_we)

endmodule

// ===== rtl/dht_ram.sv =====
module dht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dht_hash.sv =====
// Residue unit: key mod TABLE_DEPTH and probe step, one key at a time.
// Each cycle folds the bits above the modulus width back in with weight
// 2^W mod M, shrinking the value until it fits in W bits; one conditional
// subtract then gives the residue.
module dht_hash #(
  parameter int TABLE_DEPTH = 1021,
  parameter int STEP_PRIME  = 1019,
  parameter int KEY_BITS    = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [KEY_BITS-1:0]            key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] home_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] step_o
);

  localparam int SW   = $clog2(TABLE_DEPTH);
  localparam int PW   = $clog2(STEP_PRIME);
  localparam int MAXW = (KEY_BITS > SW) ? KEY_BITS : SW;
  localparam int VW   = ((MAXW > PW) ? MAXW : PW) + 1;
  // weight of the bits above the modulus width
  localparam int CD   = (1 << SW) - TABLE_DEPTH;
  localparam int CP   = (1 << PW) - STEP_PRIME;
  // raw step can reach TABLE_DEPTH or more: needs a second pass
  localparam bit NeedRed = (STEP_PRIME >= TABLE_DEPTH);

  typedef enum logic [1:0] {H_IDLE, H_KEY, H_STEP} hstate_e;

  function automatic logic [VW-1:0] fold_d(logic [VW-1:0] v);
    logic [VW-1:0] hi;
    hi = v >> SW;
    return hi * VW'(CD) + VW'(v[SW-1:0]);
  endfunction

  function automatic logic [VW-1:0] fold_s(logic [VW-1:0] v);
    logic [VW-1:0] hi;
    hi = v >> PW;
    return hi * VW'(CP) + VW'(v[PW-1:0]);
  endfunction

  // value already below 2^SW, so one subtract is enough
  function automatic logic [SW-1:0] red_d(logic [VW-1:0] v);
    return (v[SW:0] >= (SW+1)'(TABLE_DEPTH)) ? SW'(v[SW:0] - (SW+1)'(TABLE_DEPTH))
                                             : v[SW-1:0];
  endfunction

  function automatic logic [PW-1:0] red_s(logic [VW-1:0] v);
    return (v[PW:0] >= (PW+1)'(STEP_PRIME)) ? PW'(v[PW:0] - (PW+1)'(STEP_PRIME))
                                            : v[PW-1:0];
  endfunction

  hstate_e         hst_q;
  logic [VW-1:0]   vd_q, vs_q;
  logic [SW-1:0]   home_q, step_q;
  logic            done_q;

  logic            fits_home, fits_step, finish;
  logic [SW-1:0]   home_n;
  logic [PW-1:0]   rs_n;
  logic [PW:0]     step_raw;

  assign fits_home = (vd_q[VW-1:SW] == '0);
  assign fits_step = (vs_q[VW-1:PW] == '0);
  assign home_n    = red_d(vd_q);
  assign rs_n      = red_s(vs_q);
  assign step_raw  = (PW+1)'(STEP_PRIME) - {1'b0, rs_n};
  assign finish    = ((hst_q == H_KEY) && fits_home && fits_step && !NeedRed) ||
                     ((hst_q == H_STEP) && fits_home);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q  <= H_IDLE;
      vd_q   <= '0;
      vs_q   <= '0;
      home_q <= '0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= finish;
      unique case (hst_q)
        H_IDLE: begin
          if (start_i) begin
            vd_q  <= VW'(key_i);
            vs_q  <= VW'(key_i);
            hst_q <= H_KEY;
          end
        end
        H_KEY: begin
          if (fits_home && fits_step) begin
            home_q <= home_n;
            if (NeedRed) begin
              vd_q  <= VW'(step_raw);
              hst_q <= H_STEP;
            end else begin
              step_q <= SW'(step_raw);
              hst_q  <= H_IDLE;
            end
          end else begin
            vd_q <= fold_d(vd_q);
            vs_q <= fold_s(vs_q);
          end
        end
        H_STEP: begin
          if (fits_home) begin
            step_q <= home_n;
            hst_q  <= H_IDLE;
          end else begin
            vd_q <= fold_d(vd_q);
          end
        end
        default: hst_q <= H_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign home_o = home_q;
  assign step_o = step_q;

endmodule

// ===== tb/double_hash_table_tb.sv =====
`timescale 1ns / 1ps

module double_hash_table_tb;

  // Block is built at its default size; the checker mirrors these numbers.
  localparam int unsigned DEPTH  = 1021;
  localparam int unsigned PRIME  = 1019;
  localparam int unsigned KEY_W  = 31;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  // Keys spaced by DEPTH*PRIME share both home slot and probe step.
  localparam int unsigned SAME_PATH = DEPTH * PRIME;
  localparam int unsigned MAX_KEY   = (32'd1 << KEY_W) - 1;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              opcode_i;
  logic [KEY_W-1:0]  key_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [SLOT_W-1:0] slot_index_o;

  double_hash_table #(
    .TABLE_DEPTH(DEPTH),
    .STEP_PRIME (PRIME),
    .KEY_BITS   (KEY_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .slot_index_o(slot_index_o)
  );

  always #5 clk_i = ~clk_i;

  // One answer owed by the block for each accepted item, oldest first.
  typedef struct {
    dht_pkg::opcode_e  op;
    logic [KEY_W-1:0]  key;
    dht_pkg::status_e  status;
    logic [SLOT_W-1:0] slot;
  } table_answer_t;

  table_answer_t answer_q[$];

  // Shadow copy of the table. Keys are only read where the used bit is set,
  // so unwritten entries never matter.
  logic [KEY_W-1:0] shadow_key [DEPTH];
  bit               shadow_used[DEPTH];
  int unsigned      fill_count;

  // Keys offered for insert, used to build searches that hit.
  logic [KEY_W-1:0] inserted_keys[$];

  int unsigned fail_count;
  bit          source_quiet;
  bit          sink_quiet;
  int unsigned hold_off_req;

  // Walk the double-hash probe sequence exactly as the table does and
  // update the shadow copy for inserts.
  function automatic void probe_table(input dht_pkg::opcode_e op,
                                      input logic [KEY_W-1:0] key,
                                      output dht_pkg::status_e st,
                                      output logic [SLOT_W-1:0] slot);
    int unsigned pos;
    int unsigned stride;
    int unsigned n;
    st   = (op == dht_pkg::OP_INSERT) ? dht_pkg::ST_FULL : dht_pkg::ST_MISSING;
    slot = '0;
    if (op == dht_pkg::OP_INSERT && fill_count >= DEPTH) return;
    pos    = key % DEPTH;
    stride = (PRIME - key % PRIME) % DEPTH;
    for (n = 0; n < DEPTH; n++) begin
      if (!shadow_used[pos]) begin
        if (op == dht_pkg::OP_INSERT) begin
          shadow_key[pos]  = key;
          shadow_used[pos] = 1'b1;
          fill_count++;
          st   = dht_pkg::ST_INSERTED;
          slot = SLOT_W'(pos);
        end
        return;
      end
      if (op == dht_pkg::OP_SEARCH && shadow_key[pos] == key) begin
        st   = dht_pkg::ST_FOUND;
        slot = SLOT_W'(pos);
        return;
      end
      pos = (pos + stride) % DEPTH;
    end
    // Probe bound used up without a free slot or a match.
  endfunction

  // Mostly short idles, a few long ones.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Keys that pile onto a few probe chains, plus fully random ones.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = KEY_W'($urandom());
      3, 4:    k = KEY_W'($urandom_range(0, 4095));
      5, 6:    k = KEY_W'($urandom_range(0, 7) + $urandom_range(0, 2000) * DEPTH);
      7, 8:    k = KEY_W'($urandom_range(0, 7) + $urandom_range(0, 2000) * SAME_PATH);
      default: begin
        // a key already offered for insert, so inserts see duplicates
        if (inserted_keys.size() != 0)
          k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else
          k = KEY_W'($urandom());
      end
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_search_key(input int unsigned hit_pct);
    if (inserted_keys.size() != 0 && $urandom_range(0, 99) < hit_pct)
      return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    return pick_key();
  endfunction

  // Offer one item, hold it until taken, then log the answer it must produce.
  task automatic send_item(input dht_pkg::opcode_e op, input logic [KEY_W-1:0] key);
    int unsigned   gap;
    table_answer_t ans;
    gap = pick_gap(source_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    ans.op  = op;
    ans.key = key;
    probe_table(op, key, ans.status, ans.slot);
    answer_q.push_back(ans);
    if (op == dht_pkg::OP_INSERT) inserted_keys.push_back(key);
  endtask

  task automatic note_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // Empty table, collisions on a shared home slot, a chain with shared
  // home and step, step extremes, duplicates and the key range ends.
  task automatic test_directed();
    send_item(dht_pkg::OP_SEARCH, '0);                 // miss on empty table
    send_item(dht_pkg::OP_INSERT, '0);
    send_item(dht_pkg::OP_SEARCH, '0);
    send_item(dht_pkg::OP_INSERT, KEY_W'(MAX_KEY));    // all key bits set
    send_item(dht_pkg::OP_SEARCH, KEY_W'(MAX_KEY));
    send_item(dht_pkg::OP_INSERT, KEY_W'(DEPTH));      // same home as 0
    send_item(dht_pkg::OP_INSERT, '0);                 // duplicate lands further on
    send_item(dht_pkg::OP_SEARCH, KEY_W'(DEPTH));
    send_item(dht_pkg::OP_SEARCH, KEY_W'(2 * DEPTH));  // walks the chain, then misses
    send_item(dht_pkg::OP_INSERT, KEY_W'(SAME_PATH));  // same probe path as key 0
    send_item(dht_pkg::OP_SEARCH, KEY_W'(SAME_PATH));
    send_item(dht_pkg::OP_INSERT, KEY_W'(PRIME - 1));  // step of one
    send_item(dht_pkg::OP_SEARCH, KEY_W'(PRIME - 1));
    send_item(dht_pkg::OP_INSERT, KEY_W'(PRIME));      // largest step
    send_item(dht_pkg::OP_SEARCH, KEY_W'(PRIME));
    send_item(dht_pkg::OP_INSERT, KEY_W'(32'h5555_5555));
    send_item(dht_pkg::OP_INSERT, KEY_W'(32'h2AAA_AAAA));
    send_item(dht_pkg::OP_SEARCH, KEY_W'(32'h5555_5555));
    send_item(dht_pkg::OP_SEARCH, KEY_W'(32'h2AAA_AAAA));
    send_item(dht_pkg::OP_SEARCH, KEY_W'(MAX_KEY - 1)); // never stored
  endtask

  // Mixed traffic at moderate load; the first stretch runs with no idles.
  task automatic test_random_mix(input int unsigned count);
    int unsigned n;
    source_quiet = 1'b1;
    sink_quiet   = 1'b1;
    for (n = 0; n < count; n++) begin
      if (n == 60) begin
        source_quiet = 1'b0;
        sink_quiet   = 1'b0;
      end
      if ($urandom_range(0, 99) < 55) send_item(dht_pkg::OP_INSERT, pick_key());
      else send_item(dht_pkg::OP_SEARCH, pick_search_key(60));
    end
  endtask

  // Receiver stops for a long while; the sender keeps offering so the
  // output register and the item in flight back up to the input.
  task automatic test_output_stall();
    int unsigned n;
    source_quiet = 1'b1;
    hold_off_req = 300;
    for (n = 0; n < 16; n++) begin
      if (n[0]) send_item(dht_pkg::OP_SEARCH, pick_search_key(70));
      else send_item(dht_pkg::OP_INSERT, pick_key());
    end
    source_quiet = 1'b0;
  endtask

  // Insert until every slot is taken; probe chains get long near the end.
  task automatic test_fill_table();
    while (fill_count < DEPTH) begin
      if ($urandom_range(0, 99) < 10) send_item(dht_pkg::OP_SEARCH, pick_search_key(70));
      else send_item(dht_pkg::OP_INSERT, pick_key());
    end
  endtask

  // Full table: inserts are dropped, hits still resolve, and a miss has no
  // empty slot to stop at, so it runs out the whole probe bound.
  task automatic test_full_table();
    int unsigned n;
    for (n = 0; n < 40; n++) begin
      case ($urandom_range(0, 2))
        0:       send_item(dht_pkg::OP_INSERT, pick_key());
        1:       send_item(dht_pkg::OP_SEARCH, pick_search_key(100));
        default: send_item(dht_pkg::OP_SEARCH, KEY_W'($urandom()));
      endcase
    end
  endtask

  // Stimulus: reset, then each test in turn, then wait out the last answers.
  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = dht_pkg::OP_INSERT;
    key_i        = '0;
    fail_count   = 0;
    fill_count   = 0;
    source_quiet = 1'b0;
    sink_quiet   = 1'b0;
    hold_off_req = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its RAM after reset; send_item just waits on ready.
    test_directed();
    test_random_mix(250);
    test_output_stall();
    test_fill_table();
    test_full_table();
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = pick_gap(sink_quiet);
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // Compare each taken result with the oldest owed answer.
  initial begin : answer_check
    table_answer_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (answer_q.size() == 0) begin
          note_mismatch($sformatf("result with nothing owed: status %0d slot %0d",
                                  status_o, slot_index_o));
        end else begin
          want = answer_q.pop_front();
          if (status_o !== want.status || slot_index_o !== want.slot)
            note_mismatch($sformatf("%s key %0d: want status %0d slot %0d, got %0d/%0d",
                                    want.op.name(), want.key, want.status, want.slot,
                                    status_o, slot_index_o));
        end
      end
    end
  end

  // Hard stop: well past the slowest legal run (every item probing the
  // whole table behind long idles on both sides).
  initial begin : watchdog
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
